// ===== hdl/ppu_pkg.sv =====
// ppu_pkg: shared types and constants of the packed palette pixel unpacker
// used by ppu_unpack, ppu_palette and packed_palette_pixel_unpacker
package ppu_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned ROW_BYTE_W = 9;
  localparam int unsigned DEPTH_W    = 2;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned PROD_W     = 11;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SUM_W-1:0]   PAD_ROUND   = SUM_W'(31);
  localparam logic [SHIFT_W-1:0] BYTE_BITS   = SHIFT_W'(8);

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 2'd3;
  localparam logic [COL_W-1:0]   WIDTH_RESET = 8'd16;

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_PIXEL     = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_PIXEL_DEPTH = 1'b0,
    REG_ROW_WIDTH   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_code;
    logic [COL_W-1:0]   row_width;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic              row_end;
  } pal_op_t;

  function automatic logic [BYTE_W-1:0] index_mask(input logic [DEPTH_W-1:0] code);
    logic [BYTE_W-1:0] m;
    case (code)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0f;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/ppu_unpack.sv =====
// ppu_unpack: item register, index unpacking and row/column counters
// issues palette reads and writes in item order; depends on ppu_pkg
module ppu_unpack import ppu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_cmd_i,
  input  logic [BYTE_W-1:0]     in_slot_i,
  input  logic [BYTE_W-1:0]     in_code_i,
  input  logic [BYTE_W-1:0]     in_byte_i,
  input  logic                  rd_ok_i,
  output pal_op_t               op_o
);

  logic                  busy_q;
  cmd_e                  cmd_q;
  logic [BYTE_W-1:0]     slot_q, code_q, byte_q;
  logic [SHIFT_W-1:0]    shift_q;
  logic [COL_W-1:0]      col_q;
  logic [ROW_BYTE_W-1:0] rbc_q;

  logic [SHIFT_W-1:0]    bits;
  logic [SHIFT_W-1:0]    shift_n;
  logic [COL_W-1:0]      col_inc;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;
  logic [ROW_BYTE_W-1:0] limit;
  logic [ROW_BYTE_W-1:0] rbc_n;
  logic [BYTE_W-1:0]     idx;
  logic                  is_pix, can_emit, emit, last_emit, finish_pix, finish, accept;

  assign bits    = SHIFT_W'(1) << cfg_i.depth_code;
  assign shift_n = shift_q - bits;
  assign col_inc = col_q + COL_W'(1);
  assign prod    = PROD_W'(cfg_i.row_width) << cfg_i.depth_code;
  assign sum     = SUM_W'(prod) + PAD_ROUND;
  assign limit   = {sum[SUM_W-1:5], 2'b00};
  assign rbc_n   = rbc_q + ROW_BYTE_W'(1);
  assign idx     = (byte_q >> shift_n) & index_mask(cfg_i.depth_code);

  assign is_pix     = (cmd_q == CMD_PIXEL);
  assign can_emit   = busy_q && is_pix && (shift_q >= bits) && (col_q < cfg_i.row_width);
  assign emit       = can_emit && rd_ok_i;
  assign last_emit  = emit && ((shift_n < bits) || (col_inc >= cfg_i.row_width));
  assign finish_pix = busy_q && is_pix && (last_emit || !can_emit);
  assign finish     = busy_q && (!is_pix || finish_pix);
  assign in_ready_o = !busy_q || finish;
  assign accept     = in_valid_i && in_ready_o;

  assign op_o.wr_en   = busy_q && !is_pix;
  assign op_o.rd_en   = emit;
  assign op_o.addr    = is_pix ? idx : slot_q;
  assign op_o.wdata   = code_q;
  assign op_o.row_end = (col_inc == cfg_i.row_width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      shift_q <= '0;
      col_q   <= '0;
      rbc_q   <= '0;
    end else begin
      if (accept) begin
        busy_q  <= 1'b1;
        shift_q <= BYTE_BITS;
      end else begin
        if (finish) busy_q <= 1'b0;
        if (emit) shift_q <= shift_n;
      end
      if (finish_pix && (rbc_n >= limit)) begin
        rbc_q <= '0;
        col_q <= '0;
      end else begin
        if (finish_pix) rbc_q <= rbc_n;
        if (emit) col_q <= col_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      slot_q <= in_slot_i;
      code_q <= in_code_i;
      byte_q <= in_byte_i;
    end
  end

  a_rd_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o.rd_en |-> busy_q && is_pix)
    else $error("palette read issued without a pixel byte in hand");
  a_rbc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rbc_q[ROW_BYTE_W-1])
    else $error("row byte count passed the largest padded row");
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> shift_q <= BYTE_BITS)
    else $error("unpack shift out of range");
  a_emit_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> col_q != '0 || rbc_q == '0)
    else $error("column count lost after emitting a pixel");

endmodule

// ===== hdl/ppu_palette.sv =====
// ppu_palette: palette memory with per-entry valid bits and result register
// one op per cycle unless a read stalls, read data registered; depends on ppu_pkg
module ppu_palette import ppu_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pal_op_t           op_i,
  output logic              rd_ok_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_code_o,
  output logic              out_last_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [BYTE_W-1:0]        mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written_q;
  logic [BYTE_W-1:0]        rdata_q;
  logic                     hit_q;
  logic                     out_valid_q;
  logic                     last_q;
  logic                     in_range;
  logic [AW-1:0]            addr;

  assign in_range = ({1'b0, op_i.addr} < (BYTE_W+1)'(PALETTE_DEPTH));
  assign addr     = op_i.addr[AW-1:0];
  assign rd_ok_o  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (op_i.wr_en && in_range) mem[addr] <= op_i.wdata;
    if (op_i.rd_en) begin
      rdata_q <= mem[addr];
      last_q  <= op_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i.wr_en && in_range) written_q[addr] <= 1'b1;
      if (op_i.rd_en) begin
        hit_q       <= in_range && written_q[addr];
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = hit_q ? rdata_q : '0;
  assign out_last_o  = last_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.rd_en |-> rd_ok_o)
    else $error("read issued into a stalled result register");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op_i.rd_en && op_i.wr_en))
    else $error("read and write issued in the same cycle");
  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.wr_en && in_range |=> written_q[$past(addr)])
    else $error("palette write did not mark its entry");

endmodule

// ===== hdl/packed_palette_pixel_unpacker.sv =====
// packed_palette_pixel_unpacker: top level with apb register file
// instantiates ppu_unpack and ppu_palette; depends on ppu_pkg
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser cmd, tdata slot/code/byte
//   m_axis    out  m_axis_tvalid/tready       tdata pixel_code, tlast row_end
//   apb       in   psel/penable/pwrite/pready pwdata, prdata, paddr
//
// a palette write is a single op; a pixel byte issues one palette read per pixel
// emitted (1 to 8, set by the depth, fewer at a row's end), or no read when it emits nothing
// one palette read per cycle; its data is registered and offered as a beat the next cycle
// reset clears the counters and the per-entry valid bits, so the palette reads zero
// a stalled m_axis beat holds further reads; the next item is taken in the last cycle
module packed_palette_pixel_unpacker import ppu_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,  // palette_slot, palette_code, data_byte
  input  logic                  s_axis_tuser_i,  // cmd
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,  // pixel_code
  output logic                  m_axis_tlast_o,  // row_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_q;
  pal_op_t  op;
  logic     rd_ok;
  logic     cfg_wr;
  reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_code <= DEPTH_RESET;
      cfg_q.row_width  <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PIXEL_DEPTH: cfg_q.depth_code <= pwdata[DEPTH_W-1:0];
        REG_ROW_WIDTH:   cfg_q.row_width  <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PIXEL_DEPTH: prdata = APB_DATA_W'(cfg_q.depth_code);
      REG_ROW_WIDTH:   prdata = APB_DATA_W'(cfg_q.row_width);
      default:         prdata = '0;
    endcase
  end

  ppu_unpack u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .in_slot_i  (s_axis_tdata_i[7:0]),
    .in_code_i  (s_axis_tdata_i[15:8]),
    .in_byte_i  (s_axis_tdata_i[23:16]),
    .rd_ok_i    (rd_ok),
    .op_o       (op)
  );

  ppu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .rd_ok_o     (rd_ok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/sv/packed_palette_pixel_unpacker_test.sv =====
// packed_palette_pixel_unpacker_test: self-checking bench for the palette pixel unpacker
// drives palette and pixel beats plus apb register writes, checks every pixel beat
// against its own unpacking model or a directed table value; depends on ppu_pkg and packed_palette_pixel_unpacker
module packed_palette_pixel_unpacker_test;
  import ppu_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 10;
  localparam int FIXED_PHASES = 8;
  localparam int PHASE_ITEMS  = 35;
  localparam int DIR_ROWS     = 30;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_MODEL,
    ROW_NONE,
    ROW_ONE
  } row_e;

  typedef struct packed {
    row_e        kind;
    cmd_e        cmd;
    logic [7:0]  slot;
    logic [7:0]  code;
    logic [7:0]  data;
    logic [7:0]  exp_code;
    logic        exp_last;
  } row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } pixel_t;

  // config rows carry the depth code in code and the row width in data
  localparam row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_ONE,   CMD_PIXEL,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{ROW_ONE,   CMD_PIXEL,     8'h00, 8'h00, 8'hff, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PAL_WRITE, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PAL_WRITE, 8'hff, 8'ha5, 8'h00, 8'h00, 1'b0},
    '{ROW_ONE,   CMD_PIXEL,     8'h00, 8'h00, 8'h00, 8'hff, 1'b0},
    '{ROW_ONE,   CMD_PIXEL,     8'h00, 8'h00, 8'hff, 8'ha5, 1'b0},
    '{ROW_NONE,  CMD_PAL_WRITE, 8'h01, 8'h3c, 8'h00, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PAL_WRITE, 8'h0f, 8'h81, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,   CMD_PIXEL,     8'h00, 8'h00, 8'd255, 8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'h5a, 8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'h81, 8'h00, 1'b0},
    '{ROW_CFG,   CMD_PIXEL,     8'h00, 8'h00, 8'd3,  8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'ha0, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'hff, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'hff, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'hff, 8'h00, 1'b0},
    '{ROW_CFG,   CMD_PIXEL,     8'h00, 8'h01, 8'd5,  8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'he4, 8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'h1b, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,   CMD_PIXEL,     8'h00, 8'h02, 8'd1,  8'h00, 1'b0},
    '{ROW_MODEL, CMD_PIXEL,     8'h00, 8'h00, 8'hf0, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h0f, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h0f, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h0f, 8'h00, 1'b0},
    '{ROW_CFG,   CMD_PIXEL,     8'h00, 8'h03, 8'd0,  8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'h33, 8'h00, 1'b0},
    '{ROW_NONE,  CMD_PIXEL,     8'h00, 8'h00, 8'hcc, 8'h00, 1'b0}
  };

  localparam logic [1:0] PH_DEPTH [FIXED_PHASES] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
  };
  localparam logic [7:0] PH_WIDTH [FIXED_PHASES] = '{
    8'd255, 8'd1, 8'd255, 8'd7, 8'd13, 8'd255, 8'd255, 8'd1
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i;   // palette_slot, palette_code, data_byte
  logic                  s_axis_tuser_i;   // cmd
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;   // pixel_code
  logic                  m_axis_tlast_o;   // row_end
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [7:0]  pal_mem [256];
  logic [7:0]  col_cnt;
  logic [8:0]  row_byte_cnt;
  logic [1:0]  depth_q;
  logic [7:0]  width_q;
  pixel_t      pixel_q [$];
  pixel_t      want_px;

  int  err_cnt     = 0;
  int  beats_in    = 0;
  int  pixels_seen = 0;
  int  cfg_cnt     = 0;
  int  cycles      = 0;
  int  hold_left   = 0;
  bit  hold_req    = 1'b0;
  bit  hold_done   = 1'b0;
  bit  no_idle     = 1'b0;

  packed_palette_pixel_unpacker #(
    .PALETTE_DEPTH(256)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing expected: pixel_code %0h row_end %0b",
               m_axis_tdata_o, m_axis_tlast_o);
        err_cnt++;
      end else begin
        want_px = pixel_q.pop_front();
        pixels_seen++;
        if (m_axis_tdata_o !== want_px.code) begin
          $error("pixel_code: expected %0h, got %0h", want_px.code, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want_px.last) begin
          $error("row_end: expected %0b, got %0b", want_px.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  // splits one packed byte into palette colours, advancing the row counters
  task automatic unpack_pixels(input logic [7:0] data, output pixel_t res [8], output int n);
    int         bits;
    int         shift;
    int         padded;
    logic [7:0] mask;
    logic [7:0] idx;
    bits   = 1 << depth_q;
    mask   = 8'((1 << bits) - 1);
    padded = 4 * ((bits * int'(width_q) + 31) / 32);
    shift  = 8;
    n      = 0;
    while (shift >= bits && col_cnt < width_q) begin
      shift -= bits;
      col_cnt++;
      idx = (data >> shift) & mask;
      res[n] = '{pal_mem[idx], col_cnt == width_q};
      n++;
    end
    row_byte_cnt++;
    if (int'(row_byte_cnt) >= padded) begin
      row_byte_cnt = '0;
      col_cnt = '0;
    end
  endtask

  task automatic send_beat(input cmd_e cmd, input logic [7:0] slot, input logic [7:0] code,
                           input logic [7:0] data, input row_e kind, input pixel_t typed);
    pixel_t res [8];
    int     n;
    while (!no_idle && $urandom_range(99) < 19) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {data, code, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_in++;
    n = 0;
    if (cmd == CMD_PAL_WRITE) begin
      pal_mem[slot] = code;
    end else begin
      unpack_pixels(data, res, n);
    end
    case (kind)
      ROW_ONE: begin
        pixel_q.push_back(typed);
      end
      ROW_NONE: begin
      end
      default: begin
        for (int i = 0; i < n; i++) pixel_q.push_back(res[i]);
      end
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("%s readback: expected %0h, got %0h", idx.name(), value, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] depth, input logic [7:0] width);
    drain();
    apb_write(REG_PIXEL_DEPTH, APB_DATA_W'(depth));
    apb_write(REG_ROW_WIDTH, APB_DATA_W'(width));
    depth_q = depth;
    width_q = width;
    apb_read_check(REG_PIXEL_DEPTH, APB_DATA_W'(depth));
    apb_read_check(REG_ROW_WIDTH, APB_DATA_W'(width));
    cfg_cnt++;
  endtask

  initial begin
    pixel_t typed;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    m_axis_tready_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    for (int i = 0; i < 256; i++) pal_mem[i] = '0;
    col_cnt      = '0;
    row_byte_cnt = '0;
    depth_q      = DEPTH_RESET;
    width_q      = WIDTH_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(REG_PIXEL_DEPTH, APB_DATA_W'(DEPTH_RESET));
    apb_read_check(REG_ROW_WIDTH, APB_DATA_W'(WIDTH_RESET));

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        set_config(DIR_TAB[r].code[1:0], DIR_TAB[r].data);
      end else begin
        typed = '{DIR_TAB[r].exp_code, DIR_TAB[r].exp_last};
        send_beat(DIR_TAB[r].cmd, DIR_TAB[r].slot, DIR_TAB[r].code, DIR_TAB[r].data,
                  DIR_TAB[r].kind, typed);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        set_config(PH_DEPTH[p], PH_WIDTH[p]);
      end else begin
        set_config(2'($urandom_range(3)), 8'($urandom_range(255, 1)));
      end
      no_idle = (p == 6);
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // low slots are the ones narrow depths actually look up
        if ($urandom_range(99) < 25) begin
          send_beat(CMD_PAL_WRITE,
                    8'($urandom_range(1) ? $urandom_range(15) : $urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), ROW_MODEL, '0);
        end else begin
          send_beat(CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), ROW_MODEL, '0);
        end
      end
    end
    no_idle = 1'b0;
    drain();

    $display("%0d beats in, %0d pixels checked", beats_in, pixels_seen);
    $display("%0d register settings: every depth, widths 0, 1 and 255, mid-row changes",
             cfg_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
